// ===== hdl/moc_pkg.sv =====
// Shared constants, types and window reduction for the 3x3 open/close filter.
`default_nettype none

package moc_pkg;

    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 64;

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    // The stream runs two rows and two pixels past the frame while it drains.
    localparam int ROW_W = $clog2(IMAGE_HEIGHT + 3);

    // Stream index of the item that brings out the frame's last result.
    localparam int T_LAST   = IMAGE_WIDTH * IMAGE_HEIGHT + 2 * IMAGE_WIDTH + 1;
    localparam int LAST_ROW = T_LAST / IMAGE_WIDTH;
    localparam int LAST_COL = T_LAST % IMAGE_WIDTH;

    localparam logic [7:0] PIX_MAX = 8'd255;
    localparam logic [7:0] PIX_MIN = 8'd0;

    // Cell r*3+k: row r (0 = oldest), column k (0 = leftmost).
    typedef logic [8:0][7:0] win_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             push_en;
        logic [COL_W-1:0] push_addr;
    } line_ctrl_t;

    function automatic logic [7:0] pick(input logic [7:0] a, input logic [7:0] b,
                                        input logic take_max);
        logic a_wins;
        a_wins = take_max ? (a > b) : (a < b);
        return a_wins ? a : b;
    endfunction

    // Min or max over the cells of the window that lie inside the frame.
    function automatic logic [7:0] win_reduce(input win_t w, input logic edge_top,
                                              input logic edge_bot, input logic edge_left,
                                              input logic edge_right, input logic take_max);
        logic [8:0][7:0] c;
        logic [7:0]      idv;
        logic [7:0]      l0, l1, l2, l3, m0, m1, n0;
        logic            masked;
        idv = take_max ? PIX_MIN : PIX_MAX;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                masked = (r == 0 && edge_top) || (r == 2 && edge_bot) ||
                         (k == 0 && edge_left) || (k == 2 && edge_right);
                c[r * 3 + k] = masked ? idv : w[r * 3 + k];
            end
        end
        l0 = pick(c[0], c[1], take_max);
        l1 = pick(c[2], c[3], take_max);
        l2 = pick(c[4], c[5], take_max);
        l3 = pick(c[6], c[7], take_max);
        m0 = pick(l0, l1, take_max);
        m1 = pick(l2, l3, take_max);
        n0 = pick(m0, m1, take_max);
        return pick(n0, c[8], take_max);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/moc_if.sv =====
// Valid/ready stream interfaces for the filter's input and result words.
`default_nettype none

interface moc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;
    logic       drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

interface moc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/morphology_open_close_3x3_top.sv =====
// Top level: 3x3 grayscale opening/closing over a raster pixel stream.
// Throughput: one word per clock; the whole pipeline stalls only while a result
// sits unread in the output register.
// Pipeline: the word that causes a result passes v1_reg through v4_reg and then the output
// register; the result for pixel p is caused by stream word p + 2*IMAGE_WIDTH + 2.
// Reset: position counters, valid flags and mode clear at once; line stores are
// never cleared, out-of-frame neighbors are masked by position.
`default_nettype none

module morphology_open_close_3x3_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    moc_in_if.sink          in_ch,
    moc_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata
);

    localparam int COL_W = moc_pkg::COL_W;
    localparam int ROW_W = moc_pkg::ROW_W;

    typedef struct packed {
        logic             s_ok;
        logic [COL_W-1:0] s_col;
        logic             s_top;
        logic             s_bot;
        logic             s_left;
        logic             s_right;
        logic             p_ok;
        logic             p_top;
        logic             p_bot;
        logic             p_left;
        logic             p_right;
        logic             last;
        logic             closing;
    } pos_t;

    logic             mode_close_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             adv;
    logic             accept;
    logic             pix_phase;
    logic             take;
    pos_t             pos;
    logic [ROW_W-1:0] s_row, p_row;
    logic             c0, c1;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [7:0]       pix1_reg, m3_reg;
    logic [COL_W-1:0] col1_reg;
    pos_t             info1_reg, info2_reg, info3_reg, info4_reg;

    logic             out_valid_reg;
    logic [7:0]       out_pix_reg;
    logic             out_last_reg;

    moc_pkg::line_ctrl_t ctrl1, ctrl2;
    moc_pkg::win_t       win1, win2;
    logic [7:0]          mid_val, res_val;

    // Stall everything only when the output register holds an untaken word.
    assign adv          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = adv;
    assign accept       = in_ch.valid && in_ch.ready;
    assign pix_phase    = row_reg < ROW_W'(moc_pkg::IMAGE_HEIGHT);
    // Drop a drain word that arrives while pixels are still due.
    assign take         = accept && !(in_ch.drain && pix_phase);

    // Positions of the stage-one center (t - W - 1) and output (t - 2W - 2).
    always_comb
    begin
        c0 = (col_reg == '0);
        c1 = (col_reg == COL_W'(1));
        s_row = c0 ? row_reg - ROW_W'(2) : row_reg - ROW_W'(1);
        p_row = (c0 || c1) ? row_reg - ROW_W'(3) : row_reg - ROW_W'(2);

        pos.s_ok    = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && !c0);
        pos.s_col   = c0 ? COL_W'(moc_pkg::IMAGE_WIDTH - 1) : col_reg - COL_W'(1);
        pos.s_top   = (s_row == '0);
        pos.s_bot   = (s_row == ROW_W'(moc_pkg::IMAGE_HEIGHT - 1));
        pos.s_left  = c1;
        pos.s_right = c0;
        pos.p_ok    = (row_reg >= ROW_W'(3)) ||
                      (row_reg == ROW_W'(2) && !c0 && !c1);
        pos.p_top   = (p_row == '0);
        pos.p_bot   = (p_row == ROW_W'(moc_pkg::IMAGE_HEIGHT - 1));
        pos.p_left  = (col_reg == COL_W'(2));
        pos.p_right = c1;
        pos.last    = (row_reg == ROW_W'(moc_pkg::LAST_ROW)) &&
                      (col_reg == COL_W'(moc_pkg::LAST_COL));
        pos.closing = mode_close_reg;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            priority if (pos.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == COL_W'(moc_pkg::IMAGE_WIDTH - 1))
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_close_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_close_reg <= cfg_wdata;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv)
            begin
                v1_reg        <= take;
                v2_reg        <= v1_reg && info1_reg.s_ok;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg && info3_reg.p_ok;
                out_valid_reg <= v4_reg;
            end
        end
    end

    // Payload pipeline; advances with the valid flags.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix1_reg    <= pix_phase ? in_ch.pixel_in : 8'd0;
            col1_reg    <= col_reg;
            info1_reg   <= pos;
            info2_reg   <= info1_reg;
            info3_reg   <= info2_reg;
            m3_reg      <= mid_val;
            info4_reg   <= info3_reg;
            out_pix_reg <= res_val;
            out_last_reg <= info4_reg.last;
        end
    end

    always_comb
    begin
        ctrl1.rd_en     = take;
        ctrl1.rd_addr   = col_reg;
        ctrl1.push_en   = adv && v1_reg;
        ctrl1.push_addr = col1_reg;

        ctrl2.rd_en     = adv && v2_reg;
        ctrl2.rd_addr   = info2_reg.s_col;
        ctrl2.push_en   = adv && v3_reg;
        ctrl2.push_addr = info3_reg.s_col;
    end

    moc_stage u_stage_in (
        .clk      (clk),
        .ctrl     (ctrl1),
        .push_val (pix1_reg),
        .win      (win1)
    );

    moc_stage u_stage_mid (
        .clk      (clk),
        .ctrl     (ctrl2),
        .push_val (m3_reg),
        .win      (win2)
    );

    // Closing dilates first; opening erodes first.
    assign mid_val = moc_pkg::win_reduce(win1, info2_reg.s_top, info2_reg.s_bot,
                                         info2_reg.s_left, info2_reg.s_right,
                                         info2_reg.closing);
    assign res_val = moc_pkg::win_reduce(win2, info4_reg.p_top, info4_reg.p_bot,
                                         info4_reg.p_left, info4_reg.p_right,
                                         !info4_reg.closing);

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_out  = out_pix_reg;
    assign out_ch.frame_last = out_last_reg;

    a_drop_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.drain && pix_phase) |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("dropped drain word moved the stream position");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pos.last) |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not return to zero after frame end");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(moc_pkg::LAST_ROW))
        else $error("row counter ran past the drain tail");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("result word appeared without an item in the last stage");

endmodule

`default_nettype wire

// ===== hdl/moc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module moc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/moc_stage.sv =====
// One window stage: two-row line store and a 3x3 window of shift registers.
`default_nettype none

module moc_stage (
    input  wire logic                clk,
    input  wire moc_pkg::line_ctrl_t ctrl,
    input  wire logic [7:0]          push_val,
    output moc_pkg::win_t            win
);

    // Upper byte holds the older row, lower byte the newer one.
    logic [15:0]   line_rdata;
    moc_pkg::win_t win_reg;
    moc_pkg::win_t win_next;

    moc_ram #(
        .WIDTH (16),
        .DEPTH (moc_pkg::IMAGE_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ctrl.push_en),
        .waddr (ctrl.push_addr),
        .wdata ({line_rdata[7:0], push_val}),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (line_rdata)
    );

    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r * 3]     = win_reg[r * 3 + 1];
            win_next[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_next[2] = line_rdata[15:8];
        win_next[5] = line_rdata[7:0];
        win_next[8] = push_val;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push_en)
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

`default_nettype wire

// ===== tb/tb_morphology_open_close_3x3_top.sv =====
// Self-checking testbench for the 3x3 grayscale opening/closing filter.
`default_nettype none

module tb_morphology_open_close_3x3_top;

    localparam int W             = moc_pkg::IMAGE_WIDTH;
    localparam int H             = moc_pkg::IMAGE_HEIGHT;
    localparam int FRAME_PIXELS  = W * H;
    localparam int STAGE_DELAY   = W + 1;
    localparam int MAX_GAP       = 8;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } filtered_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    moc_in_if  in_ch ();
    moc_out_if out_ch ();

    morphology_open_close_3x3_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Filter state mirrored by the predictor: stage 0 works on input pixels,
    // stage 1 on the first stage's results.
    logic [7:0]     line_rows [2][2 * W];
    logic [7:0]     windows [2][9];
    int             scan_col;
    int             scan_row;
    bit             closing_mode;
    filtered_word_t expected_pixels [$];

    int         mismatch_count;
    bit         idle_enable;
    bit         long_hold_pending;
    logic [7:0] recent_pixel;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int draw_gap();
        return idle_enable ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic int stream_pos();
        return scan_row * W + scan_col;
    endfunction

    function automatic void push_column(input int stage, input int c, input logic [7:0] v);
        logic [7:0] oldest;
        logic [7:0] older;
        oldest = line_rows[stage][W + c];
        older  = line_rows[stage][c];
        line_rows[stage][W + c] = older;
        line_rows[stage][c]     = v;
        for (int r = 0; r < 3; r++)
        begin
            windows[stage][r * 3]     = windows[stage][r * 3 + 1];
            windows[stage][r * 3 + 1] = windows[stage][r * 3 + 2];
        end
        windows[stage][2] = oldest;
        windows[stage][5] = older;
        windows[stage][8] = v;
    endfunction

    // Min or max over the window cells whose frame position is valid.
    function automatic logic [7:0] window_extreme(input int stage, input int center,
                                                  input bit take_max);
        int         cr;
        int         cc;
        int         nr;
        int         nc;
        logic [7:0] acc;
        logic [7:0] v;
        if (center >= FRAME_PIXELS)
            return 8'd0;
        acc = take_max ? moc_pkg::PIX_MIN : moc_pkg::PIX_MAX;
        cr  = center / W;
        cc  = center % W;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nr = cr - 1 + r;
                nc = cc - 1 + k;
                if (nr >= 0 && nr < H && nc >= 0 && nc < W)
                begin
                    v = windows[stage][r * 3 + k];
                    if (take_max ? (v > acc) : (v < acc))
                        acc = v;
                end
            end
        end
        return acc;
    endfunction

    function automatic void predict_filter(input logic [7:0] pix, input bit drn);
        int         t;
        int         s;
        int         p;
        logic [7:0] mid;
        logic [7:0] res;
        bit         last;
        t = stream_pos();
        // drop drain words that arrive while pixels are still due
        if (drn && t < FRAME_PIXELS)
            return;
        push_column(0, scan_col, (t < FRAME_PIXELS) ? pix : 8'd0);
        if (t >= STAGE_DELAY)
        begin
            s   = t - STAGE_DELAY;
            mid = window_extreme(0, s, closing_mode);
            push_column(1, s % W, mid);
            if (s >= STAGE_DELAY)
            begin
                p = s - STAGE_DELAY;
                if (p < FRAME_PIXELS)
                begin
                    res  = window_extreme(1, p, !closing_mode);
                    last = (p == FRAME_PIXELS - 1);
                    expected_pixels.push_back('{pixel: res, last: last});
                    if (last)
                    begin
                        scan_col = 0;
                        scan_row = 0;
                        return;
                    end
                end
            end
        end
        scan_col++;
        if (scan_col >= W)
        begin
            scan_col = 0;
            scan_row++;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        filtered_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("unexpected word, pixel_out", int'(out_ch.pixel_out), -1);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_ch.pixel_out !== want.pixel)
                    report_mismatch("pixel_out", int'(out_ch.pixel_out), int'(want.pixel));
                if (out_ch.frame_last !== want.last)
                    report_mismatch("frame_last", int'(out_ch.frame_last), int'(want.last));
            end
        end
    end

    // Result side: after each word taken, stall for a random gap, or for the long hold when one is pending.
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                gap = draw_gap();
                if (long_hold_pending)
                begin
                    gap = LONG_HOLD;
                    long_hold_pending = 1'b0;
                end
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] pix, input bit drn);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.pixel_in <= pix;
        in_ch.drain    <= drn;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_filter(pix, drn);
    endtask

    // Mix of flat areas, salt and pepper and noise, so that min and max vary.
    function automatic logic [7:0] next_pixel();
        int v;
        case ($urandom_range(0, 9))
            0, 1:
                v = $urandom_range(0, 1) ? int'(moc_pkg::PIX_MAX) : int'(moc_pkg::PIX_MIN);
            2, 3, 4:
            begin
                v = int'(recent_pixel) + int'($urandom_range(0, 6)) - 3;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            default:
                v = int'($urandom_range(0, 255));
        endcase
        recent_pixel = v[7:0];
        return recent_pixel;
    endfunction

    task automatic send_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b1);
            if (stream_pos() < FRAME_PIXELS)
                send_word(next_pixel(), 1'b0);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit close_sel);
        cfg_we    <= 1'b1;
        cfg_wdata <= close_sel;
        @(posedge clk);
        cfg_we <= 1'b0;
        closing_mode = close_sel;
        @(posedge clk);
    endtask

    task automatic test_first_row_extremes();
        idle_enable = 1'b1;
        write_mode(1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h0F, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hFE, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    task automatic test_backpressure();
        send_pixels(150);
        long_hold_pending = 1'b1;
        send_pixels(200);
    endtask

    task automatic test_mode_switch_mid_frame();
        settle();
        write_mode(1'b1);
        send_pixels(200);
        settle();
        write_mode(1'b0);
        send_pixels(200);
    endtask

    task automatic test_closing_back_to_back();
        settle();
        write_mode(1'b1);
        idle_enable = 1'b0;
        send_pixels(150);
        idle_enable = 1'b1;
        settle();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.pixel_in <= 8'd0;
        in_ch.drain    <= 1'b0;
        mismatch_count    = 0;
        idle_enable       = 1'b1;
        long_hold_pending = 1'b0;
        recent_pixel      = 8'd128;
        scan_col          = 0;
        scan_row          = 0;
        closing_mode      = 1'b0;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 2 * W; i++)
                line_rows[s][i] = 8'd0;
            for (int i = 0; i < 9; i++)
                windows[s][i] = 8'd0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_row_extremes();
        test_backpressure();
        test_mode_switch_mid_frame();
        test_closing_back_to_back();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/moc_pkg.sv
hdl/moc_if.sv
hdl/moc_ram.sv
hdl/moc_stage.sv
hdl/morphology_open_close_3x3_top.sv
tb/tb_morphology_open_close_3x3_top.sv
